FILE: rtl/bicubic_hermite_surface_eval_macros.svh
// Assertion macros used by the checker of the surface evaluator.
`ifndef BICUBIC_HERMITE_SURFACE_EVAL_MACROS_SVH
`define BICUBIC_HERMITE_SURFACE_EVAL_MACROS_SVH

// Overlapping implication, sampled on clk and disabled during reset.
`define BHSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication, sampled on clk and disabled during reset.
`define BHSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bhse_pkg.sv
package bhse_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 6;
    localparam int DIM_W     = 7;
    localparam int BANK_AW   = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH = 2 ** BANK_AW;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = 1 << (FRAC_BITS - 1);
    localparam int TW        = FRAC_BITS + 1;
    localparam int HW        = FRAC_BITS + 3;
    localparam int PW        = HW + 32;
    localparam int SW        = PW + 2;
    localparam int GW        = SW - FRAC_BITS;
    localparam int QW        = GW + HW;
    localparam int AW        = QW + 2;
    localparam int RW        = AW - FRAC_BITS;
    localparam int PIPE_LAT  = 10;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        REG_LEFT,
        REG_TOP,
        REG_RIGHT,
        REG_BOTTOM,
        REG_INV_W,
        REG_INV_H,
        REG_COLS,
        REG_ROWS
    } cfg_reg_t;

    typedef struct packed {
        logic              func;
        logic [5:0]        node_col;
        logic [5:0]        node_row;
        logic signed [31:0] node_value;
        logic signed [31:0] node_slope_x;
        logic signed [31:0] node_slope_y;
        logic signed [31:0] node_slope_xy;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] surface_value;
        logic              result_valid;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] fxy;
        logic signed [31:0] fy;
        logic signed [31:0] fx;
        logic signed [31:0] f;
    } node_t;

    typedef struct packed {
        logic vld;
        logic query;
        logic inb;
    } ctl_t;

endpackage

FILE: rtl/bicubic_hermite_surface_eval.sv
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+-------------------------------
// item in   | start, busy, item_in           | taken when start && !busy
// config    | cfg_we, cfg_index, cfg_data    | written when cfg_we is high
// result    | done, result                   | one cycle, done strobe
//
// One item enters every cycle; busy stays low.
// A result passes through the pipeline registers in order: bounds, the
// 32x32 position multiply, the banked node read, basis, two product/sum rows.
// The four corners of a cell sit in four node banks by column and row parity,
// so one read per bank per cycle serves a query. Reset clears control registers
// only; node contents are undefined until written. The receiver cannot stall.
module bicubic_hermite_surface_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bhse_pkg::in_item_t item_in,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output bhse_pkg::out_item_t result
);
    import bhse_pkg::*;

    logic signed [31:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [31:0]        inv_w_reg, inv_h_reg;
    logic [DIM_W-1:0]   cols_reg, rows_reg;

    ctl_t               ctl_reg [1:9];
    ctl_t               ctl_next;

    // Stage 1 and 2
    in_item_t           item1_reg, item2_reg;
    logic [31:0]        dx_reg, dy_reg;
    logic               edge_x1_reg, edge_y1_reg, edge_x2_reg, edge_y2_reg;
    logic [63:0]        prodx_reg, prody_reg;

    // Stage 3 onward
    logic               cx0_reg, cy0_reg;
    logic [TW-1:0]      tx3_reg, ty3_reg, tx4_reg, ty4_reg, tx5_reg, ty5_reg;
    logic [TW-1:0]      tx2_4_reg, ty2_4_reg, tx2_5_reg, ty2_5_reg, tx3_5_reg, ty3_5_reg;
    node_t              rd_data_reg [4];
    node_t              c4_reg [4];
    node_t              c5_reg [4];
    node_t              c6_reg [4];
    logic signed [HW-1:0] hx_reg [4];
    logic signed [HW-1:0] hy6_reg [4];
    logic signed [HW-1:0] hy7_reg [4];
    logic signed [HW-1:0] hy8_reg [4];
    logic signed [PW-1:0] prod_reg [4][4];
    logic signed [GW-1:0] g_reg [4];
    logic signed [QW-1:0] q_reg [4];

    logic               done_reg;
    out_item_t          result_reg;

    // Stage A combinational
    logic signed [32:0] dx_wide, dy_wide;
    logic               in_x, in_y;

    // Stage 2 combinational
    logic [DIM_W-1:0]   cols_cl, rows_cl, last_cx, last_cy;
    logic               sat_x, sat_y;
    logic [COL_W-1:0]   cx;
    logic [ROW_W-1:0]   cy;
    logic [TW-1:0]      tx, ty;
    logic [BANK_AW-1:0] rd_addr [4];
    logic [BANK_AW-1:0] wr_addr;
    logic [3:0]         wr_en;
    node_t              wr_data;

    // Later combinational
    logic [TW-1:0]      tx2, ty2, tx3c, ty3c;
    logic signed [HW-1:0] hx_next [4];
    logic signed [HW-1:0] hy_next [4];
    logic signed [31:0] fm [4][4];
    logic signed [GW-1:0] g_next [4];
    logic signed [RW-1:0] p_round;
    logic signed [31:0] p_sat;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= 32'sd65536;
            bottom_reg <= 32'sd65536;
            inv_w_reg  <= 32'd65536;
            inv_h_reg  <= 32'd65536;
            cols_reg   <= 7'd2;
            rows_reg   <= 7'd2;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT:   left_reg   <= signed'(cfg_data);
                REG_TOP:    top_reg    <= signed'(cfg_data);
                REG_RIGHT:  right_reg  <= signed'(cfg_data);
                REG_BOTTOM: bottom_reg <= signed'(cfg_data);
                REG_INV_W:  inv_w_reg  <= cfg_data;
                REG_INV_H:  inv_h_reg  <= cfg_data;
                REG_COLS:   cols_reg   <= cfg_data[DIM_W-1:0];
                REG_ROWS:   rows_reg   <= cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Bounds check and offset from the top-left corner
    always_comb
    begin
        in_x    = (item_in.query_x >= left_reg) && (item_in.query_x <= right_reg);
        in_y    = (item_in.query_y >= top_reg) && (item_in.query_y <= bottom_reg);
        dx_wide = 33'(item_in.query_x) - 33'(left_reg);
        dy_wide = 33'(item_in.query_y) - 33'(top_reg);
        ctl_next.vld   = start;
        ctl_next.query = (item_in.func == FUNC_QUERY);
        ctl_next.inb   = in_x && in_y;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 9; s++)
            begin
                ctl_reg[s] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg[1] <= ctl_next;
            for (int s = 2; s <= 9; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            done_reg <= ctl_reg[9].vld;
        end
    end

    // Stages 1 and 2: position in cell units as unsigned Q32.32
    always_ff @(posedge clk) begin
        item1_reg   <= item_in;
        dx_reg      <= dx_wide[31:0];
        dy_reg      <= dy_wide[31:0];
        edge_x1_reg <= (item_in.query_x == right_reg);
        edge_y1_reg <= (item_in.query_y == bottom_reg);
        item2_reg   <= item1_reg;
        edge_x2_reg <= edge_x1_reg;
        edge_y2_reg <= edge_y1_reg;
        prodx_reg   <= 64'(dx_reg) * 64'(inv_w_reg);
        prody_reg   <= 64'(dy_reg) * 64'(inv_h_reg);
    end

    // Cell location, clamped to the last cell at fraction one
    always_comb
    begin
        cols_cl = (cols_reg < 7'd2) ? 7'd2 :
                  (cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_reg;
        rows_cl = (rows_reg < 7'd2) ? 7'd2 :
                  (rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg;
        last_cx = cols_cl - 7'd2;
        last_cy = rows_cl - 7'd2;
        sat_x   = edge_x2_reg || (prodx_reg[63:32] > 32'(last_cx));
        sat_y   = edge_y2_reg || (prody_reg[63:32] > 32'(last_cy));
        cx      = sat_x ? last_cx[COL_W-1:0] : prodx_reg[32 +: COL_W];
        cy      = sat_y ? last_cy[ROW_W-1:0] : prody_reg[32 +: ROW_W];
        tx      = sat_x ? TW'(ONE) : {1'b0, prodx_reg[31 -: FRAC_BITS]};
        ty      = sat_y ? TW'(ONE) : {1'b0, prody_reg[31 -: FRAC_BITS]};
    end

    // Bank b holds nodes with column parity b[0] and row parity b[1].
    always_comb
    begin
        logic [COL_W-1:0] colb;
        logic [ROW_W-1:0] rowb;
        for (int b = 0; b < 4; b++)
        begin
            colb = cx + COL_W'(cx[0] ^ b[0]);
            rowb = cy + ROW_W'(cy[0] ^ b[1]);
            rd_addr[b] = {rowb[ROW_W-1:1], colb[COL_W-1:1]};
            wr_en[b] = ctl_reg[2].vld && !ctl_reg[2].query &&
                       ({item2_reg.node_row[0], item2_reg.node_col[0]} == 2'(b));
        end
        wr_addr = {item2_reg.node_row[ROW_W-1:1], item2_reg.node_col[COL_W-1:1]};
        wr_data.f   = item2_reg.node_value;
        wr_data.fx  = item2_reg.node_slope_x;
        wr_data.fy  = item2_reg.node_slope_y;
        wr_data.fxy = item2_reg.node_slope_xy;
    end

    // Writes and reads share one stage, so a query always sees every
    // earlier write and no forwarding path is needed.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        node_t mem [BANK_DEPTH];

        always_ff @(posedge clk) begin
            if (wr_en[b])
            begin
                mem[wr_addr] <= wr_data;
            end
            rd_data_reg[b] <= mem[rd_addr[b]];
        end
    end

    // Basis polynomials
    always_comb
    begin
        logic signed [HW:0] t_s, t2_s, t3_s, w0, w1, w2, w3;
        tx2  = TW'((2*TW)'(tx3_reg) * (2*TW)'(tx3_reg) + (2*TW)'(HALF) >> FRAC_BITS);
        ty2  = TW'((2*TW)'(ty3_reg) * (2*TW)'(ty3_reg) + (2*TW)'(HALF) >> FRAC_BITS);
        tx3c = TW'((2*TW)'(tx2_4_reg) * (2*TW)'(tx4_reg) + (2*TW)'(HALF) >> FRAC_BITS);
        ty3c = TW'((2*TW)'(ty2_4_reg) * (2*TW)'(ty4_reg) + (2*TW)'(HALF) >> FRAC_BITS);
        for (int a = 0; a < 2; a++)
        begin
            t_s  = signed'((HW+1)'(a == 0 ? tx5_reg : ty5_reg));
            t2_s = signed'((HW+1)'(a == 0 ? tx2_5_reg : ty2_5_reg));
            t3_s = signed'((HW+1)'(a == 0 ? tx3_5_reg : ty3_5_reg));
            w0 = signed'((HW+1)'(ONE)) - 3 * t2_s + 2 * t3_s;
            w1 = 3 * t2_s - 2 * t3_s;
            w2 = t_s - 2 * t2_s + t3_s;
            w3 = t3_s - t2_s;
            if (a == 0)
            begin
                hx_next[0] = HW'(w0);
                hx_next[1] = HW'(w1);
                hx_next[2] = HW'(w2);
                hx_next[3] = HW'(w3);
            end
            else
            begin
                hy_next[0] = HW'(w0);
                hy_next[1] = HW'(w1);
                hy_next[2] = HW'(w2);
                hy_next[3] = HW'(w3);
            end
        end
    end

    // Corners in order: (cx,cy), (cx+1,cy), (cx,cy+1), (cx+1,cy+1)
    always_ff @(posedge clk) begin
        cx0_reg   <= cx[0];
        cy0_reg   <= cy[0];
        tx3_reg   <= tx;
        ty3_reg   <= ty;
        c4_reg[0] <= rd_data_reg[{cy0_reg, cx0_reg}];
        c4_reg[1] <= rd_data_reg[{cy0_reg, ~cx0_reg}];
        c4_reg[2] <= rd_data_reg[{~cy0_reg, cx0_reg}];
        c4_reg[3] <= rd_data_reg[{~cy0_reg, ~cx0_reg}];
        tx4_reg   <= tx3_reg;
        ty4_reg   <= ty3_reg;
        tx2_4_reg <= tx2;
        ty2_4_reg <= ty2;
        c5_reg    <= c4_reg;
        tx5_reg   <= tx4_reg;
        ty5_reg   <= ty4_reg;
        tx2_5_reg <= tx2_4_reg;
        ty2_5_reg <= ty2_4_reg;
        tx3_5_reg <= tx3c;
        ty3_5_reg <= ty3c;
        c6_reg    <= c5_reg;
        hx_reg    <= hx_next;
        hy6_reg   <= hy_next;
    end

    // Corner matrix F: rows f/fx by x corner, columns f/fy by y corner
    always_comb
    begin
        fm[0][0] = c6_reg[0].f;  fm[0][1] = c6_reg[2].f;
        fm[0][2] = c6_reg[0].fy; fm[0][3] = c6_reg[2].fy;
        fm[1][0] = c6_reg[1].f;  fm[1][1] = c6_reg[3].f;
        fm[1][2] = c6_reg[1].fy; fm[1][3] = c6_reg[3].fy;
        fm[2][0] = c6_reg[0].fx;  fm[2][1] = c6_reg[2].fx;
        fm[2][2] = c6_reg[0].fxy; fm[2][3] = c6_reg[2].fxy;
        fm[3][0] = c6_reg[1].fx;  fm[3][1] = c6_reg[3].fx;
        fm[3][2] = c6_reg[1].fxy; fm[3][3] = c6_reg[3].fxy;
    end

    always_comb
    begin
        logic signed [SW-1:0] acc;
        for (int j = 0; j < 4; j++)
        begin
            acc = SW'(prod_reg[0][j]) + SW'(prod_reg[1][j]) + SW'(prod_reg[2][j]) +
                  SW'(prod_reg[3][j]) + SW'(HALF);
            g_next[j] = GW'(acc >>> FRAC_BITS);
        end
    end

    always_comb
    begin
        logic signed [AW-1:0] acc;
        acc = AW'(q_reg[0]) + AW'(q_reg[1]) + AW'(q_reg[2]) + AW'(q_reg[3]) + AW'(HALF);
        p_round = RW'(acc >>> FRAC_BITS);
        if (p_round > RW'(signed'(32'h7FFFFFFF)))
        begin
            p_sat = signed'(32'h7FFFFFFF);
        end
        else if (p_round < RW'(signed'(32'h80000000)))
        begin
            p_sat = signed'(32'h80000000);
        end
        else
        begin
            p_sat = p_round[31:0];
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[i][j] <= PW'(hx_reg[i]) * PW'(fm[i][j]);
            end
            q_reg[i] <= QW'(g_reg[i]) * QW'(hy8_reg[i]);
        end
        hy7_reg <= hy6_reg;
        g_reg   <= g_next;
        hy8_reg <= hy7_reg;
        if (ctl_reg[9].query)
        begin
            result_reg.surface_value <= ctl_reg[9].inb ? p_sat : '0;
            result_reg.result_valid  <= ctl_reg[9].inb;
        end
        else
        begin
            // Node indexes always fit the grid, so a write is always stored.
            result_reg.surface_value <= '0;
            result_reg.result_valid  <= 1'b1;
        end
    end

endmodule

FILE: rtl/bhse_checker.sv
`include "bicubic_hermite_surface_eval_macros.svh"

module bhse_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input bhse_pkg::in_item_t  item_in,
    input logic                done,
    input bhse_pkg::out_item_t result
);
    import bhse_pkg::*;

    // Every accepted item yields exactly one result a fixed time later.
    `BHSE_ASSERT_IMP(a_latency, start && !busy, ##PIPE_LAT done, "item without result")
    `BHSE_ASSERT_NXT(a_no_orphan, !(start && !busy), ##(PIPE_LAT-1) !done, "result without item")
    `BHSE_ASSERT_IMP(a_invalid_zero, done && !result.result_valid, result.surface_value == 32'sd0, "invalid result not zero")
    `BHSE_ASSERT_IMP(a_write_ack, start && !busy && item_in.func == FUNC_WRITE, ##PIPE_LAT (done && result.result_valid && result.surface_value == 32'sd0), "write not acknowledged")

endmodule

bind bicubic_hermite_surface_eval bhse_checker u_bhse_checker (.*);

FILE: dv/tb_bicubic_hermite_surface_eval.sv
module tb_bicubic_hermite_surface_eval;
    timeunit 1ns;
    timeprecision 1ps;
    import bhse_pkg::*;

    class surface_scoreboard;
        bit [31:0] regs [8];
        node_t nodes [MAX_COLS * MAX_ROWS];
        out_item_t expected_q [$];
        int errors;

        function new();
            regs[REG_LEFT] = 0;
            regs[REG_TOP] = 0;
            regs[REG_RIGHT] = ONE;
            regs[REG_BOTTOM] = ONE;
            regs[REG_INV_W] = ONE;
            regs[REG_INV_H] = ONE;
            regs[REG_COLS] = 2;
            regs[REG_ROWS] = 2;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, bit [31:0] data);
            regs[idx] = (idx == REG_COLS || idx == REG_ROWS) ? {25'd0, data[6:0]} : data;
        endfunction

        function int dim(cfg_reg_t idx, int maxv);
            int v;
            v = regs[idx];
            if (v < 2)
                return 2;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function longint sreg(cfg_reg_t idx);
            return longint'($signed(regs[idx]));
        endfunction

        function bit point_inside(longint x, longint y);
            return !(x < sreg(REG_LEFT) || x > sreg(REG_RIGHT) ||
                     y < sreg(REG_TOP) || y > sreg(REG_BOTTOM));
        endfunction

        // Cell index and fraction along one axis for a point inside the bounds.
        function void locate(longint q, longint lo, longint hi, bit [31:0] inv,
                             int ncells, output int cell_idx, output longint frac);
            bit [63:0] offs;
            bit [63:0] prod;
            offs = q - lo;
            prod = offs * {32'd0, inv};
            cell_idx = int'(prod[63:32]);
            frac = longint'(prod[31:32-FRAC_BITS]);
            if (q == hi || prod[63:32] > ncells - 1) begin
                cell_idx = ncells - 1;
                frac = ONE;
            end
        endfunction

        function void cell_of(longint x, longint y, output int cx, output int cy);
            longint t;
            locate(x, sreg(REG_LEFT), sreg(REG_RIGHT), regs[REG_INV_W],
                   dim(REG_COLS, MAX_COLS) - 1, cx, t);
            locate(y, sreg(REG_TOP), sreg(REG_BOTTOM), regs[REG_INV_H],
                   dim(REG_ROWS, MAX_ROWS) - 1, cy, t);
        endfunction

        function longint round_q(longint v);
            return (v + HALF) >>> FRAC_BITS;
        endfunction

        function void hermite(longint t, output longint h [4]);
            longint t2, t3;
            t2 = round_q(t * t);
            t3 = round_q(t2 * t);
            h[0] = ONE - 3 * t2 + 2 * t3;
            h[1] = 3 * t2 - 2 * t3;
            h[2] = t - 2 * t2 + t3;
            h[3] = t3 - t2;
        endfunction

        function out_item_t surface_at(in_item_t it);
            out_item_t o;
            longint x, y, tx, ty, acc, p;
            longint hx [4], hy [4], g [4];
            longint fm [4][4];
            int cx, cy;
            node_t c00, c10, c01, c11;
            o = '0;
            x = longint'(it.query_x);
            y = longint'(it.query_y);
            if (!point_inside(x, y))
                return o;
            locate(x, sreg(REG_LEFT), sreg(REG_RIGHT), regs[REG_INV_W],
                   dim(REG_COLS, MAX_COLS) - 1, cx, tx);
            locate(y, sreg(REG_TOP), sreg(REG_BOTTOM), regs[REG_INV_H],
                   dim(REG_ROWS, MAX_ROWS) - 1, cy, ty);
            c00 = nodes[cy * MAX_COLS + cx];
            c10 = nodes[cy * MAX_COLS + cx + 1];
            c01 = nodes[(cy + 1) * MAX_COLS + cx];
            c11 = nodes[(cy + 1) * MAX_COLS + cx + 1];
            fm[0] = '{c00.f, c01.f, c00.fy, c01.fy};
            fm[1] = '{c10.f, c11.f, c10.fy, c11.fy};
            fm[2] = '{c00.fx, c01.fx, c00.fxy, c01.fxy};
            fm[3] = '{c10.fx, c11.fx, c10.fxy, c11.fxy};
            hermite(tx, hx);
            hermite(ty, hy);
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int i = 0; i < 4; i++)
                    acc += hx[i] * fm[i][j];
                g[j] = round_q(acc);
            end
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += g[j] * hy[j];
            p = round_q(acc);
            if (p > 64'sh7FFF_FFFF)
                p = 64'sh7FFF_FFFF;
            if (p < -64'sh8000_0000)
                p = -64'sh8000_0000;
            o.surface_value = p[31:0];
            o.result_valid = 1'b1;
            return o;
        endfunction

        function void note_input(in_item_t it);
            out_item_t o;
            node_t n;
            if (it.func == FUNC_WRITE) begin
                n.f = it.node_value;
                n.fx = it.node_slope_x;
                n.fy = it.node_slope_y;
                n.fxy = it.node_slope_xy;
                nodes[it.node_row * MAX_COLS + it.node_col] = n;
                o = '0;
                o.result_valid = 1'b1;
            end else begin
                o = surface_at(it);
            end
            expected_q.push_back(o);
        endfunction

        task report(string what);
            $display("error at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.surface_value !== want.surface_value)
                report($sformatf("surface_value %0d, expected %0d",
                                 got.surface_value, want.surface_value));
            if (got.result_valid !== want.result_valid)
                report($sformatf("result_valid %0b, expected %0b",
                                 got.result_valid, want.result_valid));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item_in;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    out_item_t   result;

    surface_scoreboard sb = new();
    bit written [MAX_COLS * MAX_ROWS];
    int idle_pct;
    int sent;
    int cycles;

    bicubic_hermite_surface_eval dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item_in(item_in),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .result(result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(result);
            if (cfg_we)
                sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (start && !busy)
                sb.note_input(item_in);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000) begin
            $display("bicubic_hermite_surface_eval: mismatch");
            $finish;
        end
    end

    function bit [31:0] node_word();
        if ($urandom_range(3) == 0)
            return $urandom;
        return $urandom_range(8 * ONE) - 4 * ONE;
    endfunction

    // Random fill, so fields that an item does not use carry noise.
    function in_item_t rand_item();
        bit [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return in_item_t'(raw[$bits(in_item_t)-1:0]);
    endfunction

    task send(in_item_t it);
        item_in <= it;
        start <= 1'b1;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        sent++;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task write_node(int col, int row, bit [31:0] f, bit [31:0] fx, bit [31:0] fy,
                    bit [31:0] fxy);
        in_item_t it;
        it = rand_item();
        it.func = FUNC_WRITE;
        it.node_col = 6'(col);
        it.node_row = 6'(row);
        it.node_value = f;
        it.node_slope_x = fx;
        it.node_slope_y = fy;
        it.node_slope_xy = fxy;
        written[row * MAX_COLS + col] = 1'b1;
        send(it);
    endtask

    // Corners of the target cell get written first, so no query reads an empty node.
    task query(bit [31:0] x, bit [31:0] y);
        in_item_t it;
        int cx, cy, idx;
        if (sb.point_inside(longint'($signed(x)), longint'($signed(y)))) begin
            sb.cell_of(longint'($signed(x)), longint'($signed(y)), cx, cy);
            for (int d = 0; d < 4; d++) begin
                idx = (cy + d / 2) * MAX_COLS + cx + d % 2;
                if (!written[idx])
                    write_node(cx + d % 2, cy + d / 2, node_word(), node_word(),
                               node_word(), node_word());
            end
        end
        it = rand_item();
        it.func = FUNC_QUERY;
        it.query_x = x;
        it.query_y = y;
        send(it);
    endtask

    task settle();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task set_reg(cfg_reg_t idx, bit [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task configure(bit [31:0] l, bit [31:0] t, bit [31:0] r, bit [31:0] b,
                   bit [31:0] iw, bit [31:0] ih, bit [31:0] nc, bit [31:0] nr);
        settle();
        set_reg(REG_LEFT, l);
        set_reg(REG_TOP, t);
        set_reg(REG_RIGHT, r);
        set_reg(REG_BOTTOM, b);
        set_reg(REG_INV_W, iw);
        set_reg(REG_INV_H, ih);
        set_reg(REG_COLS, nc);
        set_reg(REG_ROWS, nr);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function bit [31:0] coord(cfg_reg_t lo_reg, cfg_reg_t hi_reg);
        longint lo, hi;
        bit [63:0] span;
        lo = sb.sreg(lo_reg);
        hi = sb.sreg(hi_reg);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'(lo);
            2: return 32'(hi);
            3: return 32'(lo - $urandom_range(1, 3));
            4: return 32'(hi + $urandom_range(1, 3));
            default: begin
                if (hi < lo)
                    return $urandom;
                span = hi - lo + 1;
                return 32'(lo + longint'({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    task random_items(int count);
        for (int k = 0; k < count; k++) begin
            idle_pct = (sent < 700) ? 21 : (sent < 1400) ? 48 : 0;
            if ($urandom_range(99) < 30)
                write_node($urandom_range(63), $urandom_range(63), node_word(),
                           node_word(), node_word(), node_word());
            else
                query(coord(REG_LEFT, REG_RIGHT), coord(REG_TOP, REG_BOTTOM));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item_in = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LEFT;
        cfg_data = '0;
        cycles = 0;
        sent = 0;
        idle_pct = 21;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: one cell, corners at the extremes.
        write_node(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_node(1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        write_node(0, 1, 32'h0001_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        write_node(1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_node(63, 63, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h1);
        query(0, 0);
        query(ONE, ONE);
        query(ONE, 0);
        query(0, ONE);
        query(ONE / 2, ONE / 2);
        query(ONE / 3, 3 * ONE / 4);
        query(-1, 0);
        query(0, ONE + 1);
        query(32'h7FFF_FFFF, 32'h8000_0000);
        random_items(100);

        configure(0, 0, 8 * ONE, 8 * ONE, ONE, ONE, 9, 9);
        random_items(200);
        // Reciprocal rounded high: cells past the last one saturate.
        configure(0, 0, 5 * ONE, 3 * ONE, 32'hFFFF_FFFF, 2 * ONE, 5, 3);
        random_items(150);
        configure(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  1, 32'h0, 0, 127);
        random_items(150);
        // Reversed bounds: every query lies outside.
        configure(ONE, ONE, -ONE, -ONE, ONE, ONE, 64, 64);
        random_items(60);
        configure(-3 * ONE, 2 * ONE, 60 * ONE, 40 * ONE, ONE, ONE / 2, 64, 20);
        random_items(200);
        repeat (3) begin
            configure($urandom_range(ONE * 4) - 2 * ONE, -$urandom_range(ONE * 4),
                      $urandom_range(ONE * 40), $urandom_range(ONE * 40),
                      $urandom_range(2 * ONE), $urandom_range(2 * ONE),
                      $urandom_range(127), $urandom_range(127));
            random_items(120);
        end

        settle();
        if (sb.errors == 0)
            $display("bicubic_hermite_surface_eval: match");
        else
            $display("bicubic_hermite_surface_eval: mismatch");
        $finish;
    end
endmodule
